// ----- sv/pga_pkg.sv -----
// ----------------------------------------------------------------------------
// pga_pkg - shared types and constants for the proximity graph path finder
// Request and result layouts, controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package pga_pkg;

	localparam int MAX_NODES = 32;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int CNT_W     = IDX_W + 1;
	localparam int CRD_W     = 24;
	localparam int SQ_W      = CRD_W + 1;     // root of a squared distance
	localparam int D2_W      = 2 * SQ_W;      // squared distance, 16 frac bits
	localparam int LIM_W     = 25;
	localparam int COST_W    = 32;

	localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(2560);

	// request action codes
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_FIND  = 2'd2;
	localparam logic [1:0] ACT_NONE  = 2'd3;

	// result status codes
	localparam logic [1:0] STS_POINT  = 2'd0;
	localparam logic [1:0] STS_NOPATH = 2'd1;
	localparam logic [1:0] STS_DONE   = 2'd2;
	localparam logic [1:0] STS_FULL   = 2'd3;

	typedef struct packed {
		logic [1:0]              action;
		logic signed [CRD_W-1:0] pos_x;
		logic signed [CRD_W-1:0] pos_y;
		logic signed [CRD_W-1:0] pos_z;
		logic signed [CRD_W-1:0] goal_x;
		logic signed [CRD_W-1:0] goal_y;
		logic signed [CRD_W-1:0] goal_z;
	} pga_req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [IDX_W-1:0]        node_index;
		logic signed [CRD_W-1:0] point_x;
		logic signed [CRD_W-1:0] point_y;
		logic signed [CRD_W-1:0] point_z;
		logic                    is_goal_point;
		logic                    last;
	} pga_res_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
		logic signed [CRD_W-1:0] z;
	} pga_pt_t;

	typedef enum logic [1:0] {PA_HOLD, PA_POS, PA_GOAL, PA_NODE} pa_sel_t;
	typedef enum logic [2:0] {OK_DONE, OK_FULL, OK_NOPATH, OK_NODE, OK_GOAL} out_kind_t;
	typedef enum logic {CE_START, CE_UPD} ce_src_t;

	typedef struct packed {
		logic             in_ld;
		logic             node_we;
		logic [IDX_W-1:0] nw_addr;
		logic [IDX_W-1:0] nrd_addr;
		pa_sel_t          pa_sel;
		logic             best_ld;
		logic             sq_start;
		logic [IDX_W-1:0] ar_addr;
		logic             h_we;
		logic             ce_we;
		ce_src_t          ce_src;
		logic [IDX_W-1:0] ce_par;
		logic             flags_clr;
		logic             open_set;
		logic             open_clr;
		logic             hp_set;
		logic             sel_ld;
		logic             cost_ld;
		logic             t_ld;
		logic             pm_we;
		logic [IDX_W-1:0] pm_addr;
		logic [IDX_W-1:0] pm_data;
		logic             out_ld;
		out_kind_t        out_kind;
	} pga_cmd_t;

	typedef struct packed {
		logic             d2_lt;
		logic             in_range;
		logic             sq_done;
		logic             est_lt;
		logic             improve;
		logic             open_at;
		logic             hp_at;
		logic [IDX_W-1:0] parent;
		logic [IDX_W-1:0] prd;
		logic             out_free;
	} pga_sts_t;

	function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
			input logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
	endfunction

endpackage

// ----- sv/pga_isqrt.sv -----
// ----------------------------------------------------------------------------
// pga_isqrt - iterative integer square root, rounded down
// One result bit per cycle; done pulses once the root is final.
// ----------------------------------------------------------------------------
module pga_isqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [pga_pkg::D2_W-1:0] din,
	output logic                     done,
	output logic [pga_pkg::SQ_W-1:0] root
);
	import pga_pkg::*;

	localparam int SQ_CW = $clog2(SQ_W);
	localparam int REM_W = SQ_W + 2;

	logic              busy_q, done_q;
	logic [SQ_CW-1:0]  cnt_q;
	logic [D2_W-1:0]   v_q;
	logic [REM_W-1:0]  rem_q;
	logic [SQ_W-1:0]   root_q;
	logic [REM_W+1:0]  rem_n, trial, diff;

	assign rem_n = {rem_q, v_q[D2_W-1 -: 2]};
	assign trial = (REM_W+2)'({root_q, 2'b01});
	assign diff  = rem_n - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQ_CW'(SQ_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= din;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q <= v_q << 2;
			if (rem_n >= trial) begin
				rem_q  <= diff[REM_W-1:0];
				root_q <= {root_q[SQ_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n[REM_W-1:0];
				root_q <= {root_q[SQ_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- sv/pga_dpath.sv -----
// ----------------------------------------------------------------------------
// pga_dpath - node table, search arrays, distance pipe and result register
// Executes controller commands; reports compares and flags as status.
// ----------------------------------------------------------------------------
module pga_dpath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pga_pkg::pga_cmd_t         cmd,
	output pga_pkg::pga_sts_t         sts,
	input  pga_pkg::pga_req_t         req,
	input  logic                      cfg_we,
	input  logic [pga_pkg::LIM_W-1:0] cfg_wdata,
	input  logic                      res_stall,
	output logic                      res_valid,
	output pga_pkg::pga_res_t         res
);
	import pga_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0]  par;
		logic [COST_W-1:0] cost;
		logic [COST_W-1:0] est;
	} ce_t;

	pga_pt_t           nmem [MAX_NODES];
	logic [COST_W-1:0] hmem [MAX_NODES];
	ce_t               cemem [MAX_NODES];
	logic [IDX_W-1:0]  pmem [MAX_NODES];

	pga_pt_t           nrd_q, goal_q, pa_q, req_pt;
	logic [COST_W-1:0] h_rd_q;
	ce_t               ce_rd_q, ce_wd;
	logic [IDX_W-1:0]  prd_q;
	logic [MAX_NODES-1:0] open_q, hp_q;

	logic [LIM_W-1:0]     limit_q;
	logic [LIM_W:0]       lim_p1;
	logic [2*LIM_W+1:0]   lim2_q;

	logic [CRD_W-1:0]     adx, ady, adz;
	logic [2*CRD_W-1:0]   sqx_s1, sqy_s1, sqz_s1;
	logic [D2_W-1:0]      d2_s2, best_d2_q;
	logic [COST_W-1:0]    best_est_q, cur_cost_q, t_q;

	logic                 sq_done;
	logic [SQ_W-1:0]      sq_root;

	pga_res_t             res_n, res_q;
	logic                 res_v_q, out_free;

	function automatic logic [CRD_W-1:0] abs_diff(input logic signed [CRD_W-1:0] a,
			input logic signed [CRD_W-1:0] b);
		logic signed [CRD_W:0] d;
		d = a - b;
		return d[CRD_W] ? CRD_W'(-d) : d[CRD_W-1:0];
	endfunction

	assign req_pt = '{x: req.pos_x, y: req.pos_y, z: req.pos_z};

	// config register and squared reach, (limit+1)^2
	assign lim_p1 = {1'b0, limit_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		lim2_q <= lim_p1 * lim_p1;
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (cmd.node_we) nmem[cmd.nw_addr] <= req_pt;
		nrd_q <= nmem[cmd.nrd_addr];
		if (cmd.h_we) hmem[cmd.ar_addr] <= COST_W'(sq_root);
		h_rd_q <= hmem[cmd.ar_addr];
		if (cmd.ce_we) cemem[cmd.ar_addr] <= ce_wd;
		ce_rd_q <= cemem[cmd.ar_addr];
		if (cmd.pm_we) pmem[cmd.pm_addr] <= cmd.pm_data;
		prd_q <= pmem[cmd.pm_addr];
	end

	always_comb begin
		ce_wd.par = cmd.ce_par;
		if (cmd.ce_src == CE_START) begin
			ce_wd.cost = '0;
			ce_wd.est  = h_rd_q;
		end else begin
			ce_wd.cost = t_q;
			ce_wd.est  = sat_add(t_q, h_rd_q);
		end
	end

	// squared distance pipe: pa_q against the node read port
	assign adx = abs_diff(pa_q.x, nrd_q.x);
	assign ady = abs_diff(pa_q.y, nrd_q.y);
	assign adz = abs_diff(pa_q.z, nrd_q.z);

	always_ff @(posedge clk) begin
		sqx_s1 <= adx * adx;
		sqy_s1 <= ady * ady;
		sqz_s1 <= adz * adz;
		d2_s2  <= D2_W'(sqx_s1) + D2_W'(sqy_s1) + D2_W'(sqz_s1);
	end

	pga_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sq_start),
		.din    (d2_s2),
		.done   (sq_done),
		.root   (sq_root)
	);

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.in_ld) goal_q <= '{x: req.goal_x, y: req.goal_y, z: req.goal_z};
		unique case (cmd.pa_sel)
			PA_POS:  pa_q <= req_pt;
			PA_GOAL: pa_q <= goal_q;
			PA_NODE: pa_q <= nrd_q;
			default: ;
		endcase
		if (cmd.best_ld) best_d2_q <= d2_s2;
		if (cmd.sel_ld) best_est_q <= ce_rd_q.est;
		if (cmd.cost_ld) cur_cost_q <= ce_rd_q.cost;
		if (cmd.t_ld) t_q <= sat_add(cur_cost_q, COST_W'(sq_root));
	end

	// open set and parent-known flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			hp_q   <= '0;
		end else if (cmd.flags_clr) begin
			open_q <= '0;
			hp_q   <= '0;
		end else begin
			if (cmd.open_set) open_q[cmd.ar_addr] <= 1'b1;
			if (cmd.open_clr) open_q[cmd.ar_addr] <= 1'b0;
			if (cmd.hp_set) hp_q[cmd.ar_addr] <= 1'b1;
		end
	end

	// result register
	assign out_free = !res_v_q || !res_stall;

	always_comb begin
		res_n = '0;
		res_n.last = 1'b1;
		unique case (cmd.out_kind)
			OK_DONE:   res_n.status = STS_DONE;
			OK_FULL:   res_n.status = STS_FULL;
			OK_NOPATH: res_n.status = STS_NOPATH;
			OK_NODE: begin
				res_n.status     = STS_POINT;
				res_n.node_index = prd_q;
				res_n.point_x    = nrd_q.x;
				res_n.point_y    = nrd_q.y;
				res_n.point_z    = nrd_q.z;
				res_n.last       = 1'b0;
			end
			OK_GOAL: begin
				res_n.status        = STS_POINT;
				res_n.point_x       = goal_q.x;
				res_n.point_y       = goal_q.y;
				res_n.point_z       = goal_q.z;
				res_n.is_goal_point = 1'b1;
			end
			default: res_n.status = STS_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (cmd.out_ld) begin
			res_v_q <= 1'b1;
		end else if (!res_stall) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) res_q <= res_n;
	end

	assign res_valid = res_v_q;
	assign res       = res_q;

	// status back to the controller
	assign sts.d2_lt    = d2_s2 < best_d2_q;
	assign sts.in_range = {2'b00, d2_s2} < lim2_q;
	assign sts.sq_done  = sq_done;
	assign sts.est_lt   = ce_rd_q.est < best_est_q;
	assign sts.improve  = t_q < ce_rd_q.cost;
	assign sts.open_at  = open_q[cmd.ar_addr];
	assign sts.hp_at    = hp_q[cmd.ar_addr];
	assign sts.parent   = ce_rd_q.par;
	assign sts.prd      = prd_q;
	assign sts.out_free = out_free;

endmodule

// ----- sv/pga_ctrl.sv -----
// ----------------------------------------------------------------------------
// pga_ctrl - sequencer for table updates, snapping, A* search and path output
// Holds node count and search indices; drives datapath commands.
// ----------------------------------------------------------------------------
module pga_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        action,
	output logic              req_stall,
	input  pga_pkg::pga_sts_t sts,
	output pga_pkg::pga_cmd_t cmd
);
	import pga_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_WAIT, ST_SN_CMP, ST_CHK_SAME, ST_H_PA, ST_H_SQ, ST_H_WT,
		ST_INIT, ST_SEL_START, ST_SEL_CMP, ST_SEL_DONE, ST_EXP,
		ST_NB_START, ST_NB_CHK, ST_NB_SQ, ST_NB_UPD, ST_NB_NEXT,
		ST_PT_WR, ST_PT_RD, ST_EP_A, ST_EP_B, ST_EP_OUT,
		ST_EMIT_GOAL, ST_EMIT
	} state_t;

	state_t            state_q, ret_q;
	logic [1:0]        wt_q;
	logic [CNT_W-1:0]  cnt_q, k_q, km1;
	logic [IDX_W-1:0]  i_q, s_q, g_q, bi_q, cur_q, c_q, na_q, aa_q, nb;
	logic              found_q, phase_q;
	out_kind_t         kind_q;
	logic              last_i, snap_upd, take, not_full, do_upd;

	assign last_i   = (CNT_W'(i_q) + 1'b1) == cnt_q;
	assign snap_upd = (i_q == '0) || sts.d2_lt;
	assign nb       = snap_upd ? i_q : bi_q;
	assign take     = sts.open_at && (!found_q || sts.est_lt);
	assign not_full = cnt_q != CNT_W'(MAX_NODES);
	assign do_upd   = !((i_q == s_q) || sts.hp_at) || sts.improve;
	assign km1      = k_q - 1'b1;
	assign req_stall = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			wt_q    <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
			i_q     <= '0;
			s_q     <= '0;
			g_q     <= '0;
			bi_q    <= '0;
			cur_q   <= '0;
			c_q     <= '0;
			na_q    <= '0;
			aa_q    <= '0;
			found_q <= 1'b0;
			phase_q <= 1'b0;
			kind_q  <= OK_DONE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						unique case (action)
							ACT_CLEAR: begin
								cnt_q   <= '0;
								kind_q  <= OK_DONE;
								state_q <= ST_EMIT;
							end
							ACT_ADD: begin
								if (not_full) begin
									cnt_q  <= cnt_q + 1'b1;
									kind_q <= OK_DONE;
								end else begin
									kind_q <= OK_FULL;
								end
								state_q <= ST_EMIT;
							end
							ACT_FIND: begin
								if (cnt_q == '0) begin
									kind_q  <= OK_NOPATH;
									state_q <= ST_EMIT;
								end else begin
									phase_q <= 1'b0;
									i_q     <= '0;
									na_q    <= '0;
									wt_q    <= 2'd2;
									ret_q   <= ST_SN_CMP;
									state_q <= ST_WAIT;
								end
							end
							ACT_NONE: ;
						endcase
					end
				end
				ST_WAIT: begin
					if (wt_q == '0) state_q <= ret_q;
					else wt_q <= wt_q - 1'b1;
				end
				ST_SN_CMP: begin
					bi_q <= nb;
					if (last_i) begin
						if (!phase_q) begin
							s_q     <= nb;
							phase_q <= 1'b1;
							i_q     <= '0;
							na_q    <= '0;
							wt_q    <= 2'd2;
							ret_q   <= ST_SN_CMP;
							state_q <= ST_WAIT;
						end else begin
							g_q     <= nb;
							state_q <= ST_CHK_SAME;
						end
					end else begin
						i_q     <= i_q + 1'b1;
						na_q    <= i_q + 1'b1;
						wt_q    <= 2'd2;
						ret_q   <= ST_SN_CMP;
						state_q <= ST_WAIT;
					end
				end
				ST_CHK_SAME: begin
					if (s_q == g_q) begin
						state_q <= ST_EMIT_GOAL;
					end else begin
						na_q    <= g_q;
						wt_q    <= '0;
						ret_q   <= ST_H_PA;
						state_q <= ST_WAIT;
					end
				end
				ST_H_PA: begin
					i_q     <= '0;
					na_q    <= '0;
					wt_q    <= 2'd2;
					ret_q   <= ST_H_SQ;
					state_q <= ST_WAIT;
				end
				ST_H_SQ: begin
					aa_q    <= i_q;
					state_q <= ST_H_WT;
				end
				ST_H_WT: begin
					if (sts.sq_done) begin
						if (last_i) begin
							aa_q    <= s_q;
							wt_q    <= '0;
							ret_q   <= ST_INIT;
						end else begin
							i_q     <= i_q + 1'b1;
							na_q    <= i_q + 1'b1;
							wt_q    <= 2'd2;
							ret_q   <= ST_H_SQ;
						end
						state_q <= ST_WAIT;
					end
				end
				ST_INIT: state_q <= ST_SEL_START;
				ST_SEL_START: begin
					found_q <= 1'b0;
					i_q     <= '0;
					aa_q    <= '0;
					wt_q    <= '0;
					ret_q   <= ST_SEL_CMP;
					state_q <= ST_WAIT;
				end
				ST_SEL_CMP: begin
					if (take) begin
						cur_q   <= i_q;
						found_q <= 1'b1;
					end
					if (last_i) begin
						state_q <= ST_SEL_DONE;
					end else begin
						i_q     <= i_q + 1'b1;
						aa_q    <= i_q + 1'b1;
						wt_q    <= '0;
						ret_q   <= ST_SEL_CMP;
						state_q <= ST_WAIT;
					end
				end
				ST_SEL_DONE: begin
					if (!found_q) begin
						kind_q  <= OK_NOPATH;
						state_q <= ST_EMIT;
					end else begin
						aa_q    <= cur_q;
						na_q    <= cur_q;
						wt_q    <= '0;
						ret_q   <= ST_EXP;
						state_q <= ST_WAIT;
					end
				end
				ST_EXP: begin
					if (cur_q == g_q) begin
						k_q     <= '0;
						c_q     <= g_q;
						aa_q    <= g_q;
						state_q <= ST_PT_WR;
					end else begin
						i_q     <= '0;
						state_q <= ST_NB_START;
					end
				end
				ST_NB_START: begin
					if (i_q == cur_q) begin
						state_q <= ST_NB_NEXT;
					end else begin
						na_q    <= i_q;
						aa_q    <= i_q;
						wt_q    <= 2'd2;
						ret_q   <= ST_NB_CHK;
						state_q <= ST_WAIT;
					end
				end
				ST_NB_CHK: state_q <= sts.in_range ? ST_NB_SQ : ST_NB_NEXT;
				ST_NB_SQ: begin
					if (sts.sq_done) state_q <= ST_NB_UPD;
				end
				ST_NB_UPD: state_q <= ST_NB_NEXT;
				ST_NB_NEXT: begin
					if (last_i) begin
						state_q <= ST_SEL_START;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_NB_START;
					end
				end
				ST_PT_WR: begin
					if (k_q == CNT_W'(MAX_NODES)) begin
						kind_q  <= OK_NOPATH;
						state_q <= ST_EMIT;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= sts.hp_at ? ST_PT_RD : ST_EP_A;
					end
				end
				ST_PT_RD: begin
					c_q     <= sts.parent;
					aa_q    <= sts.parent;
					state_q <= ST_PT_WR;
				end
				ST_EP_A: state_q <= ST_EP_B;
				ST_EP_B: begin
					na_q    <= sts.prd;
					wt_q    <= '0;
					ret_q   <= ST_EP_OUT;
					state_q <= ST_WAIT;
				end
				ST_EP_OUT: begin
					if (sts.out_free) begin
						k_q     <= km1;
						state_q <= (k_q == CNT_W'(1)) ? ST_EMIT_GOAL : ST_EP_A;
					end
				end
				ST_EMIT_GOAL: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.pa_sel   = PA_HOLD;
		cmd.ce_src   = CE_START;
		cmd.out_kind = kind_q;
		cmd.nw_addr  = cnt_q[IDX_W-1:0];
		cmd.nrd_addr = na_q;
		cmd.ar_addr  = aa_q;
		cmd.ce_par   = cur_q;
		cmd.pm_data  = c_q;
		cmd.pm_addr  = (state_q == ST_PT_WR) ? k_q[IDX_W-1:0] : km1[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ld   = req_valid;
				cmd.node_we = req_valid && (action == ACT_ADD) && not_full;
				if (req_valid && (action == ACT_FIND)) cmd.pa_sel = PA_POS;
			end
			ST_SN_CMP: begin
				cmd.best_ld = snap_upd;
				if (last_i && !phase_q) cmd.pa_sel = PA_GOAL;
			end
			ST_CHK_SAME: cmd.flags_clr = (s_q != g_q);
			ST_H_PA:     cmd.pa_sel = PA_NODE;
			ST_H_SQ:     cmd.sq_start = 1'b1;
			ST_H_WT:     cmd.h_we = sts.sq_done;
			ST_INIT: begin
				cmd.ce_we    = 1'b1;
				cmd.open_set = 1'b1;
			end
			ST_SEL_CMP:  cmd.sel_ld = take;
			ST_EXP: begin
				cmd.open_clr = 1'b1;
				cmd.cost_ld  = 1'b1;
				cmd.pa_sel   = PA_NODE;
			end
			ST_NB_CHK:   cmd.sq_start = sts.in_range;
			ST_NB_SQ:    cmd.t_ld = sts.sq_done;
			ST_NB_UPD: begin
				cmd.ce_we    = do_upd;
				cmd.ce_src   = CE_UPD;
				cmd.hp_set   = do_upd;
				cmd.open_set = do_upd;
			end
			ST_PT_WR:    cmd.pm_we = (k_q != CNT_W'(MAX_NODES));
			ST_EP_OUT: begin
				cmd.out_ld   = sts.out_free;
				cmd.out_kind = OK_NODE;
			end
			ST_EMIT_GOAL: begin
				cmd.out_ld   = sts.out_free;
				cmd.out_kind = OK_GOAL;
			end
			ST_EMIT:     cmd.out_ld = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ----- sv/proximity_graph_astar_path_core.sv -----
// ----------------------------------------------------------------------------
// proximity_graph_astar_path_core - A* path finder over a 3-D proximity graph
// Node table load/clear, nearest-node snapping, A* search with on-the-fly
// Euclidean edges, and path output from start to goal.
// ----------------------------------------------------------------------------
//
//  port group   direction  handshake             carries
//  ----------   ---------  --------------------  -------------------------------
//  req          in         req_valid/req_stall   action, start pos, goal pos
//  res          out        res_valid/res_stall   status, node, point, goal, last
//  cfg          in         cfg_we                walk_limit (25b, 8 frac bits)
//
//  Work per request: clear/add go straight to a result. A find snaps start and
//  goal to their nearest nodes, runs a per-node heuristic pass, then per
//  expansion selects from the open set and checks each neighbor, taking the
//  bit-serial square root only for in-range neighbors, then emits path nodes.
//  Reset: arst_n clears node count, flags, FSM and sets walk_limit to 2560.
//  req_stall is high while a request is in work; a stalled result holds in
//  the output register and the engine waits on it before loading the next.
//
module proximity_graph_astar_path_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  pga_pkg::pga_req_t         req,
	output logic                      res_valid,
	input  logic                      res_stall,
	output pga_pkg::pga_res_t         res,
	input  logic                      cfg_we,
	input  logic [pga_pkg::LIM_W-1:0] cfg_wdata
);
	import pga_pkg::*;

	pga_cmd_t cmd;
	pga_sts_t sts;

	// sequencer: owns all indices and the search loop order
	pga_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.action    (req.action),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage, distance pipe, square root and result register
	pga_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res)
	);

	// any non-point result is the only and final one for its request
	a_nonpoint_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.status != STS_POINT)) |-> res.last)
		else $error("non-point result without last");

	// goal point closes the sequence and carries node index zero
	a_goal_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.is_goal_point) |-> (res.last && (res.node_index == '0)))
		else $error("goal point malformed");

	// an intermediate result is always a path node
	a_mid_point: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.last) |-> ((res.status == STS_POINT) && !res.is_goal_point))
		else $error("intermediate result not a path node");

	// an accepted real request occupies the engine next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && (req.action != ACT_NONE)) |=> req_stall)
		else $error("engine idle after accepting a request");

endmodule
